>>> sv/wvq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvq_pkg
// Shared constants, types and the distance weight table of the weighted
// vector quantizer.
// ----------------------------------------------------------------------------
package wvq_pkg;

    localparam int CB_SIZE   = 8;
    localparam int VEC_DIM   = 12;
    localparam int IDX_W     = (CB_SIZE > 1) ? $clog2(CB_SIZE) : 1;
    localparam int ENTRY_W   = 3;
    localparam int K_W       = 4;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 48;
    localparam int BEST_W    = 3;
    localparam int CW_DEPTH  = CB_SIZE * VEC_DIM;
    localparam int CW_AW     = $clog2(CW_DEPTH);
    localparam int WGT_W     = 6;
    localparam int SQ_W      = 2 * VAL_W;
    localparam int TERM_W    = SQ_W + WGT_W;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic             OP_LOAD  = 1'b0;
    localparam logic             OP_QUERY = 1'b1;
    localparam logic [K_W-1:0]   FIRST_K  = '0;
    localparam logic [K_W-1:0]   LAST_K   = K_W'(VEC_DIM - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic             busy;
        logic             launch;
        logic             load_we;
        logic             issue;
        logic [IDX_W-1:0] idx;
    } ctrl_t;

    function automatic logic [WGT_W-1:0] tok_weight(input logic [K_W-1:0] k);
        logic [WGT_W-1:0] w;
        unique case (k)
            4'd0:    w = 6'd1;
            4'd1:    w = 6'd3;
            4'd2:    w = 6'd7;
            4'd3:    w = 6'd13;
            4'd4:    w = 6'd19;
            4'd5:    w = 6'd22;
            4'd6:    w = 6'd25;
            4'd7:    w = 6'd33;
            4'd8:    w = 6'd42;
            4'd9:    w = 6'd50;
            4'd10:   w = 6'd56;
            4'd11:   w = 6'd61;
            default: w = 6'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> sv/weighted_vector_quantizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_vector_quantizer
// Nearest-codeword search with a weighted squared distance. Codebook and
// running sums live in two RAMs; a five-stage pipeline reads, accumulates
// and writes back one codeword per cycle and tracks the running minimum.
// ----------------------------------------------------------------------------
// Load beat: written in the accept cycle, busy stays low, next beat at once.
// Query beat: busy while the codewords go one per cycle through the single
//   codebook read port and then the five pipeline stages; the result strobe
//   done follows the query for the last coefficient, high in the cycle busy falls.
// Reset clears control and marks all running sums as zero; the codebook is
// undefined until loaded. No clearing pass. The receiver cannot stall.
module weighted_vector_quantizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [2:0]  entry,
    input  wire logic [3:0]  coeff_index,
    input  wire logic signed [15:0] value,
    output logic             done,
    output logic [2:0]       best_index,
    output logic [47:0]      best_distance
);
    import wvq_pkg::*;

    ctrl_t               ctl;
    logic                drain_done;

    logic [K_W-1:0]      k_reg;
    logic [VAL_W-1:0]    val_reg;

    logic [CW_AW-1:0]    cw_waddr, cw_raddr;
    logic [VAL_W-1:0]    cw_rdata;
    logic [SUM_W-1:0]    sum_rdata;
    logic [CB_SIZE-1:0]  sum_valid_reg;

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                s4_valid_reg, s5_valid_reg;
    logic [IDX_W-1:0]    s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg, s5_idx_reg;
    logic [VAL_W-1:0]    s2_ad_reg;
    logic [SUM_W-1:0]    s2_old_reg, s3_old_reg, s4_old_reg;
    logic [SQ_W-1:0]     s3_sq_reg;
    logic [TERM_W-1:0]   s4_term_reg;
    logic [SUM_W-1:0]    s5_sum_reg;

    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]      diff_abs;
    logic [SUM_W-1:0]    old_sum;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;

    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [SUM_W-1:0]    best_dist_reg, best_dist_next;
    logic                done_reg, done_next;

    wvq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .entry       (entry),
        .coeff_index (coeff_index),
        .drain_done  (drain_done),
        .ctl         (ctl)
    );

    assign cw_waddr = CW_AW'(entry) * CW_AW'(VEC_DIM) + CW_AW'(coeff_index);
    assign cw_raddr = CW_AW'(ctl.idx) * CW_AW'(VEC_DIM) + CW_AW'(k_reg);

    wvq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CW_DEPTH)
    ) u_cw_ram (
        .clk   (clk),
        .we    (ctl.load_we),
        .waddr (cw_waddr),
        .wdata (value),
        .raddr (cw_raddr),
        .rdata (cw_rdata)
    );

    wvq_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CB_SIZE)
    ) u_sum_ram (
        .clk   (clk),
        .we    (s4_valid_reg),
        .waddr (s4_idx_reg),
        .wdata (sum_sat),
        .raddr (ctl.idx),
        .rdata (sum_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.launch)
        begin
            k_reg   <= coeff_index;
            val_reg <= value;
        end
    end

    // stage 1: RAM data back, difference and magnitude
    always_comb
    begin
        diff     = $signed({cw_rdata[VAL_W-1], cw_rdata})
                   - $signed({val_reg[VAL_W-1], val_reg});
        diff_abs = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
        // first coefficient restarts the sum; unwritten sums read as zero
        if (k_reg == FIRST_K || !sum_valid_reg[s1_idx_reg])
        begin
            old_sum = '0;
        end
        else
        begin
            old_sum = sum_rdata;
        end
    end

    // stage 4: accumulate with saturation
    always_comb
    begin
        sum_wide = {1'b0, s4_old_reg} + (SUM_W+1)'(s4_term_reg);
        if (sum_wide >= {1'b0, SUM_MAX})
        begin
            sum_sat = SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= ctl.idx;
        s2_idx_reg  <= s1_idx_reg;
        s2_ad_reg   <= diff_abs[VAL_W-1:0];
        s2_old_reg  <= old_sum;
        s3_idx_reg  <= s2_idx_reg;
        s3_sq_reg   <= s2_ad_reg * s2_ad_reg;
        s3_old_reg  <= s2_old_reg;
        s4_idx_reg  <= s3_idx_reg;
        s4_term_reg <= TERM_W'(s3_sq_reg) * TERM_W'(tok_weight(k_reg));
        s4_old_reg  <= s3_old_reg;
        s5_idx_reg  <= s4_idx_reg;
        s5_sum_reg  <= sum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            sum_valid_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            if (s4_valid_reg)
            begin
                sum_valid_reg[s4_idx_reg] <= 1'b1;
            end
            done_reg <= done_next;
        end
    end

    // stage 5: running minimum, strict compare keeps the lowest index on ties
    always_comb
    begin
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        if (s5_valid_reg && (s5_idx_reg == '0 || s5_sum_reg < best_dist_reg))
        begin
            best_idx_next  = s5_idx_reg;
            best_dist_next = s5_sum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    assign drain_done = s5_valid_reg && (s5_idx_reg == IDX_W'(CB_SIZE - 1));
    assign done_next  = drain_done && (k_reg == LAST_K);

    assign busy          = ctl.busy;
    assign done          = done_reg;
    assign best_index    = BEST_W'(best_idx_reg);
    assign best_distance = best_dist_reg;

`ifndef SYNTH
    a_done_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("result strobe not aligned with end of query");

    a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(s1_valid_reg || s2_valid_reg || s3_valid_reg
                    || s4_valid_reg || s5_valid_reg))
        else $error("pipeline active while idle");

    a_done_last_coeff: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (k_reg == LAST_K))
        else $error("result emitted for a coefficient other than the last");

    a_no_load_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !ctl.load_we)
        else $error("codebook written during a query");
`endif

endmodule
`default_nettype wire

>>> sv/wvq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wvq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> sv/wvq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wvq_ctrl
// Command decode and sequencer: walks the codewords one per cycle for a
// query, then waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module wvq_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  op,
    input  wire logic [2:0]            entry,
    input  wire logic [3:0]            coeff_index,
    input  wire logic                  drain_done,
    output wvq_pkg::ctrl_t             ctl
);
    import wvq_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;
    logic             k_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        accept      = 1'b0;
        k_ok        = (32'(coeff_index) < VEC_DIM);
        ctl.busy    = 1'b1;
        ctl.launch  = 1'b0;
        ctl.load_we = 1'b0;
        ctl.issue   = 1'b0;
        ctl.idx     = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.busy    = 1'b0;
                accept      = start;
                ctl.load_we = accept && (op == OP_LOAD) && k_ok
                              && (32'(entry) < CB_SIZE);
                ctl.launch  = accept && (op == OP_QUERY) && k_ok;
                if (ctl.launch)
                begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                ctl.issue = 1'b1;
                if (idx_reg == IDX_W'(CB_SIZE - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
